// ===== rtl/mandelbrot_escape_pixel_top_macros.svh =====
// Assertion shorthands for the escape-time pixel engine
`ifndef MANDELBROT_ESCAPE_PIXEL_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mep_pkg.sv =====
// Shared types and constants of the escape-time pixel engine
package mep_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COORD_W    = 32;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int SCALE_W    = 31;
  localparam int ITER_W     = 12;
  localparam int STEP_W     = 8;
  localparam int WORD_W     = 32;
  localparam int BOFF_W     = 26;
  localparam int PROD_W     = POS_W + SCALE_W;
  localparam int MAP_W      = PROD_W + 2;
  // z is bounded by 2.0 whenever it is squared
  localparam int MUL_W      = FRAC_BITS + 3;
  localparam int SQ_W       = 2 * MUL_W;
  localparam int Z_W        = COORD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;

  localparam logic [7:0] ALPHA_BYTE = 8'hff;

  localparam logic [SCALE_W-1:0] RST_SCALE    = 31'h2000_0000;
  localparam logic [ITER_W-1:0]  RST_MAX_ITER = 12'd256;
  localparam logic [SIZE_W-1:0]  RST_SIZE     = 13'd800;

  typedef struct packed {
    logic [SCALE_W-1:0]        scale;
    logic signed [COORD_W-1:0] x_offset;
    logic signed [COORD_W-1:0] y_offset;
    logic [ITER_W-1:0]         max_iterations;
    logic [SIZE_W-1:0]         image_width;
    logic [SIZE_W-1:0]         image_height;
  } mep_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] pixel_x;
    logic [POS_W-1:0] pixel_y;
  } mep_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] pixel_word;
    logic [BOFF_W-1:0] byte_offset;
  } mep_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
    logic [BOFF_W-1:0]         byte_offset;
  } mep_job_t;

endpackage

// ===== rtl/mandelbrot_escape_pixel_top.sv =====
// Mapping runs one divider per axis, both in parallel; the back loop then spends
//   a multiply state and an add state on each escape step before hand-over.
// While the queue has room the front maps new pixels as the back iterates; the back
//   loop limits the rate for deep points, the dividers for shallow ones.
// Reset: synchronous, clears control state and loads default configuration;
//   the queue starts empty, there is no clearing pass.
`include "mandelbrot_escape_pixel_top_macros.svh"

module mandelbrot_escape_pixel_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mep_pkg::mep_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mep_pkg::mep_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mep_pkg::*;

  mep_cfg_t cfg_r;
  logic     job_push;
  logic     job_full;
  logic     job_pop;
  logic     job_empty;
  mep_job_t job_wr;
  mep_job_t job_rd;
  logic     grey_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale          <= RST_SCALE;
      cfg_r.x_offset       <= '0;
      cfg_r.y_offset       <= '0;
      cfg_r.max_iterations <= RST_MAX_ITER;
      cfg_r.image_width    <= RST_SIZE;
      cfg_r.image_height   <= RST_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:    cfg_r.scale          <= cfg_wdata[SCALE_W-1:0];
        CFG_X_OFFSET: cfg_r.x_offset       <= $signed(cfg_wdata[COORD_W-1:0]);
        CFG_Y_OFFSET: cfg_r.y_offset       <= $signed(cfg_wdata[COORD_W-1:0]);
        CFG_MAX_ITER: cfg_r.max_iterations <= cfg_wdata[ITER_W-1:0];
        CFG_WIDTH:    cfg_r.image_width    <= cfg_wdata[SIZE_W-1:0];
        CFG_HEIGHT:   cfg_r.image_height   <= cfg_wdata[SIZE_W-1:0];
        default:      cfg_r                <= cfg_r;
      endcase
    end
  end

  mep_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_push (job_push),
    .job_full (job_full),
    .job_data (job_wr)
  );

  mep_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  mep_iter u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job_data  (job_rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign grey_word = (out_data.pixel_word[31:24] == ALPHA_BYTE) &&
                     (out_data.pixel_word[23:16] == out_data.pixel_word[7:0]) &&
                     (out_data.pixel_word[15:8] == out_data.pixel_word[7:0]);

  `MEP_ASSERT_NOW(a_no_push_full, job_push, !job_full, "job pushed into a full queue")
  `MEP_ASSERT_NOW(a_no_pop_empty, job_pop, !job_empty, "job popped from an empty queue")
  `MEP_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "front took two pixels")
  `MEP_ASSERT_NOW(a_grey_word, out_valid, grey_word, "result word not opaque grey")

endmodule

// ===== rtl/mep_div.sv =====
// Restoring divider, one quotient bit per cycle, for the coordinate mapping
module mep_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mep_pkg::PROD_W-1:0]  num,
  input  logic [mep_pkg::SIZE_W-1:0]  den,
  output logic                        done,
  output logic [mep_pkg::PROD_W-1:0]  quo
);
  import mep_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W-1:0] den_r;
  logic [PROD_W-1:0] quo_r;
  logic [SIZE_W:0]   shifted;
  logic [SIZE_W:0]   diff;
  logic              fits;

  always_comb begin
    shifted = {rem_r, quo_r[PROD_W-1]};
    diff    = shifted - {1'b0, den_r};
    fits    = shifted >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= den;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/mep_front.sv =====
// Front part: takes a pixel, maps it to a complex point and queues the job
module mep_front (
  input  logic              clk,
  input  logic              rst_n,
  input  mep_pkg::mep_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  mep_pkg::mep_in_t  in_data,
  output logic              job_push,
  input  logic              job_full,
  output mep_pkg::mep_job_t job_data
);
  import mep_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_DIVS, F_DIV, F_PUSH} front_state_t;

  front_state_t      state_r;
  logic [POS_W-1:0]  px_r;
  logic [POS_W-1:0]  py_r;
  logic [PROD_W-1:0] prod_x_r;
  logic [PROD_W-1:0] prod_y_r;
  logic [BOFF_W-1:0] lin_r;
  logic              div_start;
  logic              done_x;
  logic              done_y;
  logic [PROD_W-1:0] quo_x;
  logic [PROD_W-1:0] quo_y;
  logic [SIZE_W-1:0] den_x;
  logic [SIZE_W-1:0] den_y;

  // q - scale/2 + offset, saturated to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] map_coord(
    input logic [PROD_W-1:0]        q,
    input logic [SCALE_W-1:0]       scl,
    input logic signed [COORD_W-1:0] off
  );
    logic signed [MAP_W-1:0] t;
    logic signed [COORD_W-1:0] res;
    t = $signed({2'b00, q}) - $signed(MAP_W'(scl >> 1)) + MAP_W'(off);
    if (t[MAP_W-1:COORD_W-1] == '0 || t[MAP_W-1:COORD_W-1] == '1) begin
      res = t[COORD_W-1:0];
    end else if (t[MAP_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  // a zero size divides as one
  assign den_x = (cfg.image_width  == '0) ? SIZE_W'(1) : cfg.image_width;
  assign den_y = (cfg.image_height == '0) ? SIZE_W'(1) : cfg.image_height;

  mep_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_x_r),
    .den   (den_x),
    .done  (done_x),
    .quo   (quo_x)
  );

  mep_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_y_r),
    .den   (den_y),
    .done  (done_y),
    .quo   (quo_y)
  );

  // hold off input transfers while in reset
  assign in_ready  = (state_r == F_IDLE) && rst_n;
  assign div_start = (state_r == F_DIVS);
  assign job_push  = (state_r == F_PUSH) && !job_full;

  always_comb begin
    job_data.cr          = map_coord(quo_x, cfg.scale, cfg.x_offset);
    job_data.ci          = map_coord(quo_y, cfg.scale, cfg.y_offset);
    job_data.byte_offset = {lin_r[BOFF_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            px_r    <= in_data.pixel_x;
            py_r    <= in_data.pixel_y;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prod_x_r <= PROD_W'(px_r) * PROD_W'(cfg.scale);
          prod_y_r <= PROD_W'(py_r) * PROD_W'(cfg.scale);
          lin_r    <= BOFF_W'(py_r) * BOFF_W'(cfg.image_width) + BOFF_W'(px_r);
          state_r  <= F_DIVS;
        end
        F_DIVS: begin
          state_r <= F_DIV;
        end
        F_DIV: begin
          if (done_x && done_y) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mep_fifo.sv =====
// Job queue between the mapping front and the iteration back
module mep_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mep_pkg::mep_job_t wr_data,
  output logic              full,
  input  logic              pop,
  output mep_pkg::mep_job_t rd_data,
  output logic              empty
);
  import mep_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mep_job_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/mep_iter.sv =====
// Back part: iterates z = z*z + c for one job and registers the result
module mep_iter (
  input  logic              clk,
  input  logic              rst_n,
  input  mep_pkg::mep_cfg_t cfg,
  input  logic              job_empty,
  output logic              job_pop,
  input  mep_pkg::mep_job_t job_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mep_pkg::mep_out_t out_data
);
  import mep_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_ADD, B_DONE} back_state_t;

  localparam logic signed [Z_W-1:0] TWO_Z     = Z_W'(longint'(2) <<< FRAC_BITS);
  localparam logic signed [Z_W-1:0] NEG_TWO_Z = -TWO_Z;
  localparam logic [SQ_W-1:0]       FOUR_SQ   = SQ_W'(longint'(4) << (2 * FRAC_BITS));

  back_state_t               state_r;
  logic signed [COORD_W-1:0] cr_r;
  logic signed [COORD_W-1:0] ci_r;
  logic [BOFF_W-1:0]         boff_r;
  logic signed [Z_W-1:0]     zr_r;
  logic signed [Z_W-1:0]     zi_r;
  logic [ITER_W-1:0]         cnt_r;
  logic [STEP_W-1:0]         step_r;
  logic signed [SQ_W-1:0]    prr_r;
  logic signed [SQ_W-1:0]    pii_r;
  logic signed [SQ_W-1:0]    pri_r;
  logic                      out_valid_r;
  mep_out_t                  out_data_r;

  logic signed [MUL_W-1:0]   zr_m;
  logic signed [MUL_W-1:0]   zi_m;
  logic [SQ_W-1:0]           sq_sum;
  logic signed [SQ_W-1:0]    diff;
  logic signed [Z_W-1:0]     nr;
  logic signed [Z_W-1:0]     ni;
  logic                      esc_abs;
  logic                      esc_sq;
  logic [ITER_W-1:0]         cnt_dec;
  logic                      out_free;

  always_comb begin
    // z has passed the magnitude test here, so the narrow slice is exact
    zr_m    = zr_r[MUL_W-1:0];
    zi_m    = zi_r[MUL_W-1:0];
    sq_sum  = $unsigned(prr_r) + $unsigned(pii_r);
    diff    = prr_r - pii_r;
    nr      = Z_W'(diff >>> FRAC_BITS) + Z_W'(cr_r);
    // floor(2*zr*zi) at the fraction point
    ni      = Z_W'(pri_r >>> (FRAC_BITS - 1)) + Z_W'(ci_r);
    esc_abs = (nr > TWO_Z) || (nr < NEG_TWO_Z) || (ni > TWO_Z) || (ni < NEG_TWO_Z);
    esc_sq  = (cnt_r != '0) && (sq_sum > FOUR_SQ);
    cnt_dec = cnt_r - 1'b1;
    out_free = !out_valid_r || out_ready;
  end

  assign job_pop   = (state_r == B_IDLE) && !job_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the result state loads the next transfer itself
      if (out_valid_r && out_ready && (state_r != B_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!job_empty) begin
            cr_r    <= job_data.cr;
            ci_r    <= job_data.ci;
            boff_r  <= job_data.byte_offset;
            zr_r    <= '0;
            zi_r    <= '0;
            cnt_r   <= '0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prr_r   <= SQ_W'(zr_m) * SQ_W'(zr_m);
          pii_r   <= SQ_W'(zi_m) * SQ_W'(zi_m);
          pri_r   <= SQ_W'(zr_m) * SQ_W'(zi_m);
          state_r <= B_ADD;
        end
        B_ADD: begin
          if (esc_sq) begin
            // squares of the previous step's z exceed 4.0
            step_r  <= cnt_dec[STEP_W-1:0];
            state_r <= B_DONE;
          end else if (cnt_r == cfg.max_iterations) begin
            step_r  <= '0;
            state_r <= B_DONE;
          end else begin
            zr_r  <= nr;
            zi_r  <= ni;
            cnt_r <= cnt_r + 1'b1;
            if (esc_abs) begin
              step_r  <= cnt_r[STEP_W-1:0];
              state_r <= B_DONE;
            end else begin
              state_r <= B_MUL;
            end
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.pixel_word  <= {ALPHA_BYTE, step_r, step_r, step_r};
            out_data_r.byte_offset <= boff_r;
            state_r                <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule
